// ----- rtl/core/kld_pkg.sv -----
// Shared constants and types for the keyed substitution line decoder.
package kld_pkg;

    localparam int MAX_KEYS = 16;
    localparam int KEY_LEN  = 26;

    localparam int SLOT_W = 4;
    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;
    localparam int ACC_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CFG_W-1:0] KEYS_LIMIT = CFG_W'(MAX_KEYS);
    localparam logic [POS_W-1:0] KEY_LEN_POS = POS_W'(KEY_LEN);
    localparam logic [ACC_W+3:0] ACC_SAT = (ACC_W+4)'(255);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic [STAT_W-1:0] ST_TEXT      = 2'd0;
    localparam logic [STAT_W-1:0] ST_LINE_OK   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_COLON  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;

    typedef logic [KEY_LEN-1:0][BYTE_W-1:0] key_row_t;

endpackage

// ----- rtl/core/kld_in_if.sv -----
// Input channel carrying load and text words into the decoder.
interface kld_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [kld_pkg::SLOT_W-1:0]    slot;
    logic [kld_pkg::POS_W-1:0]     position;
    logic [kld_pkg::BYTE_W-1:0]    byte_in;
    logic                          close_line;

    modport source (output valid, cmd, slot, position, byte_in, close_line, input ready);
    modport sink   (input valid, cmd, slot, position, byte_in, close_line, output ready);
endinterface

// ----- rtl/core/kld_out_if.sv -----
// Output channel carrying decoded bytes and line status words.
interface kld_out_if;
    logic                          valid;
    logic                          ready;
    logic [kld_pkg::BYTE_W-1:0]    out_byte;
    logic [kld_pkg::STAT_W-1:0]    status;
    logic                          last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink   (input valid, out_byte, status, last, output ready);
endinterface

// ----- rtl/core/keyed_substitution_line_decoder.sv -----
// Keyed substitution line decoder: key store, line parser and byte lookup.
//
// The block takes one word per clock cycle. A word is held in an input register,
// where the index parser and a 26-way compare against the selected key run, and its
// result is loaded from there into an output register; a stalled output holds the input
// register and input ready drops. The key store is a memory of sixteen rows of 26
// bytes, read one row per cycle at the selected slot; a per-row valid bit makes
// unwritten rows read as zero, so there is no clearing pass after reset and words are
// accepted from the first cycle. A key byte loaded by a word is seen by the very next
// word.
module keyed_substitution_line_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [kld_pkg::CFG_W-1:0]   cfg_data,
    kld_in_if.sink                      item,
    kld_out_if.source                   result
);

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_SKIP,
        PH_TEXT,
        PH_BAD
    } phase_t;

    // Key store.
    kld_pkg::key_row_t key_mem [kld_pkg::MAX_KEYS];
    kld_pkg::key_row_t mem_rd_reg;

    logic [kld_pkg::MAX_KEYS-1:0]  row_valid_reg;
    logic                          rd_clear_reg;
    logic                          byp_valid_reg;
    logic [kld_pkg::POS_W-1:0]     byp_pos_reg;
    logic [kld_pkg::BYTE_W-1:0]    byp_byte_reg;

    // Input register.
    logic                          s1_valid_reg;
    logic                          s1_cmd_reg;
    logic [kld_pkg::SLOT_W-1:0]    s1_slot_reg;
    logic [kld_pkg::POS_W-1:0]     s1_pos_reg;
    logic [kld_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic                          s1_close_reg;

    // Line state and configuration.
    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [kld_pkg::ACC_W-1:0]     acc_reg;
    logic [kld_pkg::ACC_W-1:0]     acc_next;
    logic [kld_pkg::SLOT_W-1:0]    sel_reg;
    logic [kld_pkg::SLOT_W-1:0]    sel_next;
    logic [kld_pkg::CFG_W-1:0]     keys_in_use_reg;

    // Output register.
    logic                          out_valid_reg;
    logic [kld_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [kld_pkg::STAT_W-1:0]    out_status_reg;
    logic                          out_last_reg;

    kld_pkg::key_row_t             key_row;
    logic [kld_pkg::BYTE_W-1:0]    text_byte;
    logic [kld_pkg::CFG_W-1:0]     limit;
    logic                          index_ok;
    logic                          is_digit;
    logic                          is_blank;
    logic [kld_pkg::ACC_W+3:0]     acc_mul;
    logic                          have_text;
    logic                          line_end;
    logic                          res_valid;
    logic [kld_pkg::BYTE_W-1:0]    res_byte;
    logic [kld_pkg::STAT_W-1:0]    res_status;
    logic                          s1_go;
    logic                          in_fire;
    logic                          wr_en;
    logic [kld_pkg::SLOT_W-1:0]    rd_slot;

    // The row read last cycle, cleared when never written, with the byte written in
    // that same cycle laid over it.
    always_comb
    begin
        for (int p = 0; p < kld_pkg::KEY_LEN; p++)
        begin
            key_row[p] = rd_clear_reg ? '0 : mem_rd_reg[p];
            if (byp_valid_reg && byp_pos_reg == kld_pkg::POS_W'(p))
            begin
                key_row[p] = byp_byte_reg;
            end
        end
    end

    // The lowest matching position wins.
    always_comb
    begin
        text_byte = s1_byte_reg;
        for (int p = kld_pkg::KEY_LEN - 1; p >= 0; p--)
        begin
            if (key_row[p] != '0 && key_row[p] == s1_byte_reg)
            begin
                text_byte = kld_pkg::CH_A + kld_pkg::BYTE_W'(p);
            end
        end
    end

    assign limit    = (keys_in_use_reg > kld_pkg::KEYS_LIMIT) ? kld_pkg::KEYS_LIMIT
                                                              : keys_in_use_reg;
    assign index_ok = !(neg_reg && acc_reg != '0)
                      && (acc_reg < kld_pkg::ACC_W'(limit));
    assign is_digit = s1_byte_reg inside {[kld_pkg::CH_0:kld_pkg::CH_9]};
    assign is_blank = s1_byte_reg inside {kld_pkg::CH_SPACE, kld_pkg::CH_TAB, kld_pkg::CH_VT,
                                          kld_pkg::CH_FF, kld_pkg::CH_CR};
    assign acc_mul  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + {{kld_pkg::ACC_W{1'b0}}, s1_byte_reg[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sel_next   = sel_reg;
        have_text  = 1'b0;
        line_end   = 1'b0;
        res_byte   = '0;
        res_status = kld_pkg::ST_TEXT;
        if (s1_cmd_reg == kld_pkg::CMD_TEXT)
        begin
            if (s1_byte_reg != kld_pkg::CH_NL)
            begin
                case (phase_reg)
                    PH_TEXT:
                    begin
                        have_text = 1'b1;
                    end
                    PH_BAD:
                    begin
                        phase_next = PH_BAD;
                    end
                    default:
                    begin
                        if (s1_byte_reg == kld_pkg::CH_COLON)
                        begin
                            if (index_ok)
                            begin
                                sel_next   = kld_pkg::SLOT_W'(acc_reg);
                                phase_next = PH_TEXT;
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                            end
                        end
                        else if (phase_reg == PH_SPACE)
                        begin
                            if (is_blank)
                            begin
                                phase_next = PH_SPACE;
                            end
                            else if (s1_byte_reg == kld_pkg::CH_MINUS
                                     || s1_byte_reg == kld_pkg::CH_PLUS)
                            begin
                                neg_next   = (s1_byte_reg == kld_pkg::CH_MINUS);
                                phase_next = PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = kld_pkg::ACC_W'(s1_byte_reg[3:0]);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        else if (phase_reg == PH_DIGITS)
                        begin
                            if (is_digit)
                            begin
                                acc_next = (acc_mul > kld_pkg::ACC_SAT)
                                           ? kld_pkg::ACC_W'(kld_pkg::ACC_SAT)
                                           : acc_mul[kld_pkg::ACC_W-1:0];
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                endcase
            end
            line_end = (s1_byte_reg == kld_pkg::CH_NL) || s1_close_reg;
            if (line_end)
            begin
                case (phase_next)
                    PH_TEXT:
                    begin
                        res_status = kld_pkg::ST_LINE_OK;
                        res_byte   = kld_pkg::CH_NL;
                    end
                    PH_BAD:
                    begin
                        res_status = kld_pkg::ST_BAD_INDEX;
                    end
                    default:
                    begin
                        res_status = kld_pkg::ST_NO_COLON;
                    end
                endcase
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
            else if (have_text)
            begin
                res_byte = text_byte;
            end
        end
    end

    assign res_valid = s1_valid_reg && s1_cmd_reg == kld_pkg::CMD_TEXT
                       && (line_end || have_text);
    assign s1_go     = s1_valid_reg && (!res_valid || !out_valid_reg || result.ready);
    assign in_fire   = item.valid && item.ready;
    assign wr_en     = s1_go && s1_cmd_reg == kld_pkg::CMD_LOAD
                       && s1_pos_reg < kld_pkg::KEY_LEN_POS;
    assign rd_slot   = s1_go ? sel_next : sel_reg;

    assign item.ready      = !s1_valid_reg || s1_go;
    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.status   = out_status_reg;
    assign result.last     = out_last_reg;

    // A first write to a row fills the rest of it with zeros.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int p = 0; p < kld_pkg::KEY_LEN; p++)
            begin
                if (!row_valid_reg[s1_slot_reg] || s1_pos_reg == kld_pkg::POS_W'(p))
                begin
                    key_mem[s1_slot_reg][p] <= (s1_pos_reg == kld_pkg::POS_W'(p))
                                               ? s1_byte_reg : '0;
                end
            end
        end
        mem_rd_reg <= key_mem[rd_slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg   <= '0;
            rd_clear_reg    <= 1'b1;
            byp_valid_reg   <= 1'b0;
            byp_pos_reg     <= '0;
            byp_byte_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            s1_cmd_reg      <= kld_pkg::CMD_LOAD;
            s1_slot_reg     <= '0;
            s1_pos_reg      <= '0;
            s1_byte_reg     <= '0;
            s1_close_reg    <= 1'b0;
            phase_reg       <= PH_SPACE;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            sel_reg         <= '0;
            keys_in_use_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_status_reg  <= kld_pkg::ST_TEXT;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keys_in_use_reg <= cfg_data;
            end

            rd_clear_reg  <= !row_valid_reg[rd_slot];
            byp_valid_reg <= wr_en && s1_slot_reg == rd_slot;
            byp_pos_reg   <= s1_pos_reg;
            byp_byte_reg  <= s1_byte_reg;
            if (wr_en)
            begin
                row_valid_reg[s1_slot_reg] <= 1'b1;
            end

            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_cmd_reg   <= item.cmd;
                s1_slot_reg  <= item.slot;
                s1_pos_reg   <= item.position;
                s1_byte_reg  <= item.byte_in;
                s1_close_reg <= item.close_line;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                sel_reg   <= sel_next;
            end

            if (s1_go && res_valid)
            begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
                out_last_reg   <= line_end;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sim/kld_checker.sv -----
// Result checker for the line decoder: mirrors its state, predicts every result word and compares.
module kld_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [kld_pkg::CFG_W-1:0] cfg_data,
    kld_in_if                         item,
    kld_out_if                        result,
    output int                        fail_count,
    output int                        outstanding
);

    typedef enum logic [2:0]
    {
        LINE_LEAD,
        LINE_NUMBER,
        LINE_IGNORE,
        LINE_CIPHER,
        LINE_REJECT
    } line_phase_t;

    typedef struct packed
    {
        logic [kld_pkg::BYTE_W-1:0] out_byte;
        logic [kld_pkg::STAT_W-1:0] status;
        logic                       last;
    } line_result_t;

    logic [kld_pkg::BYTE_W-1:0] key_mirror [kld_pkg::MAX_KEYS][kld_pkg::KEY_LEN];
    logic [kld_pkg::CFG_W-1:0]  key_limit;
    line_phase_t                phase;
    logic                       negative;
    logic [kld_pkg::ACC_W-1:0]  index_value;
    logic [kld_pkg::SLOT_W-1:0] cipher_slot;
    line_result_t               expected_q [$];

    task automatic note_mismatch(input string msg);
        fail_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic restart_line();
        phase       = LINE_LEAD;
        negative    = 1'b0;
        index_value = '0;
    endtask

    function automatic logic [kld_pkg::BYTE_W-1:0] decipher(
        input logic [kld_pkg::BYTE_W-1:0] b);
        for (int p = 0; p < kld_pkg::KEY_LEN; p++)
        begin
            if (key_mirror[cipher_slot][p] != '0 && key_mirror[cipher_slot][p] == b)
            begin
                return kld_pkg::CH_A + kld_pkg::BYTE_W'(p);
            end
        end
        return b;
    endfunction

    task automatic absorb_word(input logic cmd, input logic [kld_pkg::SLOT_W-1:0] slot,
                               input logic [kld_pkg::POS_W-1:0] pos,
                               input logic [kld_pkg::BYTE_W-1:0] b,
                               input logic close);
        logic [kld_pkg::BYTE_W-1:0] plain;
        logic                       have_plain;
        logic                       is_digit;
        logic                       is_blank;
        int unsigned                grown;
        logic [kld_pkg::CFG_W-1:0]  limit;
        line_result_t               line_end;
        plain      = '0;
        have_plain = 1'b0;
        is_digit   = (b >= kld_pkg::CH_0 && b <= kld_pkg::CH_9);
        is_blank   = (b == kld_pkg::CH_SPACE || b == kld_pkg::CH_TAB || b == kld_pkg::CH_VT
                      || b == kld_pkg::CH_FF || b == kld_pkg::CH_CR);
        if (cmd == kld_pkg::CMD_LOAD)
        begin
            if (pos < kld_pkg::KEY_LEN_POS)
            begin
                key_mirror[slot][pos] = b;
            end
            return;
        end
        if (b != kld_pkg::CH_NL)
        begin
            if (phase == LINE_CIPHER)
            begin
                plain      = decipher(b);
                have_plain = 1'b1;
            end
            else if (phase != LINE_REJECT)
            begin
                if (b == kld_pkg::CH_COLON)
                begin
                    limit = (key_limit < kld_pkg::KEYS_LIMIT) ? key_limit
                                                              : kld_pkg::KEYS_LIMIT;
                    if (!(negative && index_value != '0) && 32'(index_value) < 32'(limit))
                    begin
                        cipher_slot = index_value[kld_pkg::SLOT_W-1:0];
                        phase       = LINE_CIPHER;
                    end
                    else
                    begin
                        phase = LINE_REJECT;
                    end
                end
                else if (phase == LINE_LEAD)
                begin
                    if (b == kld_pkg::CH_MINUS || b == kld_pkg::CH_PLUS)
                    begin
                        negative = (b == kld_pkg::CH_MINUS);
                        phase    = LINE_NUMBER;
                    end
                    else if (is_digit)
                    begin
                        index_value = b - kld_pkg::CH_0;
                        phase       = LINE_NUMBER;
                    end
                    else if (!is_blank)
                    begin
                        phase = LINE_IGNORE;
                    end
                end
                else if (phase == LINE_NUMBER)
                begin
                    if (is_digit)
                    begin
                        grown = 32'(index_value) * 10 + 32'(b) - 32'(kld_pkg::CH_0);
                        index_value = (grown > 32'(kld_pkg::ACC_SAT))
                                      ? kld_pkg::ACC_W'(kld_pkg::ACC_SAT)
                                      : kld_pkg::ACC_W'(grown);
                    end
                    else
                    begin
                        phase = LINE_IGNORE;
                    end
                end
            end
        end
        if (b == kld_pkg::CH_NL || close)
        begin
            line_end.last = 1'b1;
            case (phase)
                LINE_CIPHER:
                begin
                    line_end.status   = kld_pkg::ST_LINE_OK;
                    line_end.out_byte = kld_pkg::CH_NL;
                end
                LINE_REJECT:
                begin
                    line_end.status   = kld_pkg::ST_BAD_INDEX;
                    line_end.out_byte = '0;
                end
                default:
                begin
                    line_end.status   = kld_pkg::ST_NO_COLON;
                    line_end.out_byte = '0;
                end
            endcase
            expected_q.push_back(line_end);
            restart_line();
        end
        else if (have_plain)
        begin
            expected_q.push_back('{plain, kld_pkg::ST_TEXT, 1'b0});
        end
    endtask

    task automatic check_result();
        line_result_t want;
        if (expected_q.size() == 0)
        begin
            note_mismatch($sformatf("unexpected word byte=%02h status=%0d last=%0b",
                                    result.out_byte, result.status, result.last));
            return;
        end
        want = expected_q.pop_front();
        if (result.out_byte !== want.out_byte)
        begin
            note_mismatch($sformatf("out_byte %02h, expected %02h",
                                    result.out_byte, want.out_byte));
        end
        if (result.status !== want.status)
        begin
            note_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        end
        if (result.last !== want.last)
        begin
            note_mismatch($sformatf("last %0b, expected %0b", result.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (key_mirror[s, p])
            begin
                key_mirror[s][p] = '0;
            end
            key_limit   = '0;
            cipher_slot = '0;
            restart_line();
            expected_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                key_limit = cfg_data;
            end
            if (item.valid && item.ready)
            begin
                absorb_word(item.cmd, item.slot, item.position, item.byte_in, item.close_line);
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Regression top for the line decoder: clock, reset, key and line stimulus, flow control, verdict.
module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 62;
    localparam int SETTLE_CYCLES = 4;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [kld_pkg::CFG_W-1:0]  cfg_data;
    logic                       steady;
    logic                       hold_request;
    int                         fail_count;
    int                         outstanding;
    int                         cycle_count;
    int                         phase_words;
    logic [kld_pkg::BYTE_W-1:0] key_shadow [kld_pkg::MAX_KEYS][kld_pkg::KEY_LEN];
    logic [kld_pkg::BYTE_W-1:0] line_q [$];

    kld_in_if  item_bus ();
    kld_out_if result_bus ();

    keyed_substitution_line_decoder DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item_bus),
        .result   (result_bus)
    );

    kld_checker line_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .item        (item_bus),
        .result      (result_bus),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("keyed_substitution_line_decoder regression: fail");
        $finish;
    end

    // The output side stalls at random, except in the steady phase and during one long hold-off.
    initial
    begin
        logic hold_taken;
        hold_taken = 1'b0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    result_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            if (steady)
            begin
                result_bus.ready <= 1'b1;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [kld_pkg::SLOT_W-1:0] slot,
                             input logic [kld_pkg::POS_W-1:0] pos,
                             input logic [kld_pkg::BYTE_W-1:0] b,
                             input logic close);
        if (!steady && $urandom_range(99) < 16)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.cmd        <= cmd;
        item_bus.slot       <= slot;
        item_bus.position   <= pos;
        item_bus.byte_in    <= b;
        item_bus.close_line <= close;
        do
        begin
            @(posedge clk);
        end
        while (!item_bus.ready);
        phase_words++;
    endtask

    task automatic send_load(input logic [kld_pkg::SLOT_W-1:0] slot,
                             input logic [kld_pkg::POS_W-1:0] pos,
                             input logic [kld_pkg::BYTE_W-1:0] b);
        if (pos < kld_pkg::KEY_LEN_POS)
        begin
            key_shadow[slot][pos] = b;
        end
        send_word(kld_pkg::CMD_LOAD, slot, pos, b, 1'b0);
    endtask

    task automatic flush_line(input logic close_last);
        foreach (line_q[i])
        begin
            send_word(kld_pkg::CMD_TEXT, kld_pkg::SLOT_W'($urandom_range(15)),
                      kld_pkg::POS_W'($urandom_range(31)),
                      line_q[i], close_last && (i == line_q.size() - 1));
        end
        line_q.delete();
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key_limit(input logic [kld_pkg::CFG_W-1:0] limit);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed lines with random content; some are cut short, some are pure noise.
    task automatic random_line();
        int unsigned                shape;
        int unsigned                value;
        int unsigned                count;
        int unsigned                cut;
        string                      digits;
        logic [kld_pkg::BYTE_W-1:0] b;
        logic                       close_last;
        shape = $urandom_range(99);
        value = 0;
        if (shape < 85)
        begin
            count = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (count)
            begin
                case ($urandom_range(4))
                    0:       b = kld_pkg::CH_SPACE;
                    1:       b = kld_pkg::CH_TAB;
                    2:       b = kld_pkg::CH_VT;
                    3:       b = kld_pkg::CH_FF;
                    default: b = kld_pkg::CH_CR;
                endcase
                line_q.push_back(b);
            end
            case ($urandom_range(19))
                0, 1, 2: line_q.push_back(kld_pkg::CH_MINUS);
                3, 4:    line_q.push_back(kld_pkg::CH_PLUS);
                default: ;
            endcase
            if ($urandom_range(9) != 0)
            begin
                count = $urandom_range(19);
                if (count < 15)
                begin
                    value = $urandom_range(17);
                end
                else if (count < 18)
                begin
                    value = $urandom_range(255);
                end
                else
                begin
                    value = $urandom_range(256, 99999);
                end
                if ($urandom_range(7) == 0)
                begin
                    line_q.push_back(kld_pkg::CH_0);
                end
                digits = $sformatf("%0d", value);
                for (int i = 0; i < digits.len(); i++)
                begin
                    line_q.push_back(digits[i]);
                end
            end
            if ($urandom_range(9) == 0)
            begin
                line_q.push_back(kld_pkg::BYTE_W'($urandom_range(8'h61, 8'h7A)));
            end
            line_q.push_back(kld_pkg::CH_COLON);
            count = $urandom_range(8);
            repeat (count)
            begin
                if (value < kld_pkg::MAX_KEYS && $urandom_range(3) != 0)
                begin
                    b = key_shadow[kld_pkg::SLOT_W'(value)]
                                  [kld_pkg::POS_W'($urandom_range(kld_pkg::KEY_LEN - 1))];
                end
                else
                begin
                    b = kld_pkg::BYTE_W'($urandom_range(255));
                end
                if (b == kld_pkg::CH_NL)
                begin
                    b = kld_pkg::CH_A;
                end
                line_q.push_back(b);
            end
            if (shape >= 75)
            begin
                cut = $urandom_range(1, line_q.size());
                while (line_q.size() > cut)
                begin
                    void'(line_q.pop_back());
                end
            end
        end
        else
        begin
            count = $urandom_range(1, 8);
            repeat (count)
            begin
                case ($urandom_range(7))
                    0:       b = kld_pkg::CH_COLON;
                    1:       b = kld_pkg::CH_MINUS;
                    2:       b = kld_pkg::CH_PLUS;
                    3:       b = kld_pkg::CH_0 + kld_pkg::BYTE_W'($urandom_range(9));
                    4:       b = kld_pkg::CH_NL;
                    5:       b = kld_pkg::CH_SPACE;
                    default: b = kld_pkg::BYTE_W'($urandom_range(255));
                endcase
                line_q.push_back(b);
            end
        end
        close_last = ($urandom_range(3) == 0);
        if (!close_last || $urandom_range(5) == 0)
        begin
            line_q.push_back(kld_pkg::CH_NL);
        end
        flush_line(close_last);
    endtask

    initial
    begin
        logic [kld_pkg::CFG_W-1:0]  phase_limit [PHASES];
        logic [kld_pkg::BYTE_W-1:0] b;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        item_bus.valid      <= 1'b0;
        item_bus.cmd        <= kld_pkg::CMD_LOAD;
        item_bus.slot       <= '0;
        item_bus.position   <= '0;
        item_bus.byte_in    <= '0;
        item_bus.close_line <= 1'b0;
        steady              <= 1'b0;
        hold_request        <= 1'b0;
        phase_words = 0;
        foreach (key_shadow[s, p])
        begin
            key_shadow[s][p] = '0;
        end
        phase_limit = '{5'd31, 5'd16, 5'd0, 5'd1, 5'd9, kld_pkg::CFG_W'($urandom_range(31))};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short directed lines: negative zero index, lowest matching position, last key
        // position, zero byte passing through, close flag on a text byte, saturated index,
        // missing colon, and a load outside the key that must be ignored.
        send_load(4'd0, 5'd0, 8'h78);
        send_load(4'd0, 5'd1, 8'h78);
        send_load(4'd0, 5'd25, 8'hFF);
        send_load(4'd15, 5'd0, 8'h80);
        send_load(4'd3, 5'd31, 8'h55);
        set_key_limit(kld_pkg::KEYS_LIMIT);
        line_q = '{kld_pkg::CH_SPACE, kld_pkg::CH_MINUS, kld_pkg::CH_0, kld_pkg::CH_COLON,
                   8'h78, 8'hFF, 8'h00, kld_pkg::CH_NL};
        flush_line(1'b0);
        line_q = '{8'h31, 8'h35, kld_pkg::CH_COLON, 8'h80};
        flush_line(1'b1);
        line_q = '{8'h39, 8'h39, 8'h39, kld_pkg::CH_COLON, 8'h71, kld_pkg::CH_NL};
        flush_line(1'b0);
        line_q = '{8'h7A, kld_pkg::CH_NL};
        flush_line(1'b0);

        for (int s = 0; s < kld_pkg::MAX_KEYS; s++)
        begin
            for (int p = 0; p < kld_pkg::KEY_LEN; p++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    b = '0;
                end
                else if (p > 0 && $urandom_range(9) == 0)
                begin
                    b = key_shadow[s][$urandom_range(p - 1)];
                end
                else
                begin
                    b = kld_pkg::BYTE_W'($urandom_range(1, 255));
                end
                send_load(kld_pkg::SLOT_W'(s), kld_pkg::POS_W'(p), b);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_key_limit(phase_limit[ph]);
            steady <= (ph == 1);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                if (ph == 1 && phase_words >= 30)
                begin
                    hold_request <= 1'b1;
                end
                if ($urandom_range(99) < 8)
                begin
                    send_load(kld_pkg::SLOT_W'($urandom_range(15)),
                              kld_pkg::POS_W'($urandom_range(31)),
                              kld_pkg::BYTE_W'($urandom_range(255)));
                end
                else
                begin
                    random_line();
                end
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("keyed_substitution_line_decoder regression: pass");
        end
        else
        begin
            $display("keyed_substitution_line_decoder regression: fail");
        end
        $finish;
    end

endmodule
